[hdl/gcci_pkg.sv]
`timescale 1ns / 1ps
package gcci_pkg;

   localparam int MAX_AXIS_BITS_DEF = 10;
   localparam int COORD_W = 10;
   localparam int INDEX_W = 30;
   localparam int AXIS_REG_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 4;

   // ordering codes
   localparam logic [1:0] MODE_ROW_MAJOR = 2'd0;
   localparam logic [1:0] MODE_ZORDER = 2'd1;
   localparam logic [1:0] MODE_HILBERT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THREE_DIM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_BITS = 2'd2;

   localparam logic [1:0] CURVE_MODE_RESET = MODE_ZORDER;
   localparam logic THREE_DIM_RESET = 1'b0;
   localparam logic [AXIS_REG_W-1:0] AXIS_BITS_RESET = 4'd4;

   typedef struct packed {
      logic [1:0] curve_mode;
      logic three_dim;
      logic [AXIS_REG_W-1:0] axis_bits;
   } gcci_cfg_type;

endpackage

[hdl/gcci_prep.sv]
`timescale 1ns / 1ps
module gcci_prep #(
   parameter int MAX_AXIS_BITS = gcci_pkg::MAX_AXIS_BITS_DEF,
   parameter int CALC_W = 3 * MAX_AXIS_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  gcci_pkg::gcci_cfg_type cfg,
   input  logic valid_in,
   input  logic [gcci_pkg::COORD_W-1:0] cell_x,
   input  logic [gcci_pkg::COORD_W-1:0] cell_y,
   input  logic [gcci_pkg::COORD_W-1:0] cell_z,
   output logic valid_out,
   output logic is_hilbert_out,
   output logic [MAX_AXIS_BITS-1:0] x_out,
   output logic [MAX_AXIS_BITS-1:0] y_out,
   output logic [CALC_W-1:0] z_high_out,
   output logic [CALC_W-1:0] alt_index_out
);
   import gcci_pkg::*;

   localparam int BW = $clog2(MAX_AXIS_BITS + 1);
   localparam bit MaxOdd = (MAX_AXIS_BITS % 2) == 1;

   logic [BW-1:0] axis_eff;
   logic [MAX_AXIS_BITS-1:0] mask;
   logic [MAX_AXIS_BITS-1:0] xm, ym, zm;
   logic pre_swap;
   logic [CALC_W-1:0] row_index, z_index, z_high;

   logic valid_ff, valid_in_d;
   logic is_hilbert_ff, is_hilbert_in;
   logic [MAX_AXIS_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [CALC_W-1:0] z_high_ff, alt_index_ff, alt_index_in;

   always_comb begin
      if (cfg.axis_bits > AXIS_REG_W'(MAX_AXIS_BITS)) begin
         axis_eff = BW'(MAX_AXIS_BITS);
      end else begin
         axis_eff = BW'(cfg.axis_bits);
      end
      for (int i = 0; i < MAX_AXIS_BITS; i++) begin
         mask[i] = (i < int'(axis_eff));
      end
      xm = cell_x[MAX_AXIS_BITS-1:0] & mask;
      ym = cell_y[MAX_AXIS_BITS-1:0] & mask;
      zm = cfg.three_dim ? (cell_z[MAX_AXIS_BITS-1:0] & mask) : '0;

      z_high = CALC_W'(zm) << {axis_eff, 1'b0};
      row_index = CALC_W'(xm) | (CALC_W'(ym) << axis_eff) | z_high;

      z_index = '0;
      for (int i = 0; i < MAX_AXIS_BITS; i++) begin
         if (cfg.three_dim) begin
            z_index[3*i]   = xm[i];
            z_index[3*i+1] = ym[i];
            z_index[3*i+2] = zm[i];
         end else begin
            z_index[2*i]   = xm[i];
            z_index[2*i+1] = ym[i];
         end
      end

      // levels above the grid size only swap x and y, so fold them into one swap
      pre_swap = MaxOdd ^ axis_eff[0];
      x_in = pre_swap ? ym : xm;
      y_in = pre_swap ? xm : ym;
      alt_index_in = (cfg.curve_mode == MODE_ZORDER) ? z_index : row_index;
      is_hilbert_in = (cfg.curve_mode == MODE_HILBERT);
      valid_in_d = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         is_hilbert_ff <= is_hilbert_in;
         x_ff <= x_in;
         y_ff <= y_in;
         z_high_ff <= z_high;
         alt_index_ff <= alt_index_in;
      end
   end

   assign valid_out = valid_ff;
   assign is_hilbert_out = is_hilbert_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_high_out = z_high_ff;
   assign alt_index_out = alt_index_ff;

endmodule

[hdl/gcci_hilb_level.sv]
`timescale 1ns / 1ps
module gcci_hilb_level #(
   parameter int MAX_AXIS_BITS = gcci_pkg::MAX_AXIS_BITS_DEF,
   parameter int CALC_W = 3 * MAX_AXIS_BITS,
   parameter int LVL = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic valid_in,
   input  logic is_hilbert_in,
   input  logic [MAX_AXIS_BITS-1:0] x_in,
   input  logic [MAX_AXIS_BITS-1:0] y_in,
   input  logic [2*MAX_AXIS_BITS-1:0] dist_in,
   input  logic [CALC_W-1:0] z_high_in,
   input  logic [CALC_W-1:0] alt_index_in,
   output logic valid_out,
   output logic is_hilbert_out,
   output logic [MAX_AXIS_BITS-1:0] x_out,
   output logic [MAX_AXIS_BITS-1:0] y_out,
   output logic [2*MAX_AXIS_BITS-1:0] dist_out,
   output logic [CALC_W-1:0] z_high_out,
   output logic [CALC_W-1:0] alt_index_out
);
   import gcci_pkg::*;

   localparam logic [MAX_AXIS_BITS-1:0] LowMask =
      MAX_AXIS_BITS'((64'd1 << LVL) - 64'd1);

   logic rx, ry;
   logic [MAX_AXIS_BITS-1:0] xa, ya;

   logic valid_ff;
   logic is_hilbert_ff;
   logic [MAX_AXIS_BITS-1:0] x_ff, x_nx, y_ff, y_nx;
   logic [2*MAX_AXIS_BITS-1:0] dist_ff, dist_nx;
   logic [CALC_W-1:0] z_high_ff, alt_index_ff;

   always_comb begin
      rx = x_in[LVL];
      ry = y_in[LVL];
      // quadrant digit is (3*rx) ^ ry, placed at this level's two bits
      dist_nx = dist_in;
      dist_nx[2*LVL+1] = rx;
      dist_nx[2*LVL] = rx ^ ry;
      xa = x_in;
      ya = y_in;
      if (!ry) begin
         if (rx) begin
            xa = x_in ^ LowMask;
            ya = y_in ^ LowMask;
         end
         x_nx = ya & LowMask;
         y_nx = xa & LowMask;
      end else begin
         x_nx = xa & LowMask;
         y_nx = ya & LowMask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         is_hilbert_ff <= is_hilbert_in;
         x_ff <= x_nx;
         y_ff <= y_nx;
         dist_ff <= dist_nx;
         z_high_ff <= z_high_in;
         alt_index_ff <= alt_index_in;
      end
   end

   assign valid_out = valid_ff;
   assign is_hilbert_out = is_hilbert_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign dist_out = dist_ff;
   assign z_high_out = z_high_ff;
   assign alt_index_out = alt_index_ff;

endmodule

[hdl/grid_cell_curve_index.sv]
`timescale 1ns / 1ps
// Maps one grid cell (x, y, z) to its position along row-major, Z-order or Hilbert order
// on a grid of 2^axis_bits cells per axis (axis_bits above MAX_AXIS_BITS acts as
// MAX_AXIS_BITS). One transaction is accepted per cycle while req_stall is low; each result
// passes through a first stage for masking and the row-major and
// Z-order indexes, one pipeline stage per Hilbert level, and the output register.
// req_stall follows a stalled, full output register, and the whole pipeline holds with it.
// Registers are written through the csr port, which is always ready; write them only while the
// pipeline is empty, as the block itself does not enforce this.
module grid_cell_curve_index #(
   parameter int MAX_AXIS_BITS = gcci_pkg::MAX_AXIS_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [gcci_pkg::COORD_W-1:0] req_cell_x,
   input  logic [gcci_pkg::COORD_W-1:0] req_cell_y,
   input  logic [gcci_pkg::COORD_W-1:0] req_cell_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [gcci_pkg::INDEX_W-1:0] rsp_curve_index,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [gcci_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gcci_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gcci_pkg::*;

   localparam int CALC_W = 3 * MAX_AXIS_BITS;
   localparam int DIST_W = 2 * MAX_AXIS_BITS;

   gcci_cfg_type cfg_ff;
   logic advance;

   logic valid_s [0:MAX_AXIS_BITS];
   logic is_hilbert_s [0:MAX_AXIS_BITS];
   logic [MAX_AXIS_BITS-1:0] x_s [0:MAX_AXIS_BITS];
   logic [MAX_AXIS_BITS-1:0] y_s [0:MAX_AXIS_BITS];
   logic [DIST_W-1:0] dist_s [0:MAX_AXIS_BITS];
   logic [CALC_W-1:0] z_high_s [0:MAX_AXIS_BITS];
   logic [CALC_W-1:0] alt_index_s [0:MAX_AXIS_BITS];

   logic rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_mode <= CURVE_MODE_RESET;
         cfg_ff.three_dim <= THREE_DIM_RESET;
         cfg_ff.axis_bits <= AXIS_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CURVE_MODE: cfg_ff.curve_mode <= csr_wdata[1:0];
            CSR_THREE_DIM: cfg_ff.three_dim <= csr_wdata[0];
            CSR_AXIS_BITS: cfg_ff.axis_bits <= csr_wdata[AXIS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // the pipeline moves unless a result sits in the output register and is stalled
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   gcci_prep #(
      .MAX_AXIS_BITS(MAX_AXIS_BITS),
      .CALC_W(CALC_W)
   ) u_prep (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .cfg(cfg_ff),
      .valid_in(req_valid),
      .cell_x(req_cell_x),
      .cell_y(req_cell_y),
      .cell_z(req_cell_z),
      .valid_out(valid_s[0]),
      .is_hilbert_out(is_hilbert_s[0]),
      .x_out(x_s[0]),
      .y_out(y_s[0]),
      .z_high_out(z_high_s[0]),
      .alt_index_out(alt_index_s[0])
   );

   assign dist_s[0] = '0;

   for (genvar k = 0; k < MAX_AXIS_BITS; k++) begin : g_level
      gcci_hilb_level #(
         .MAX_AXIS_BITS(MAX_AXIS_BITS),
         .CALC_W(CALC_W),
         .LVL(MAX_AXIS_BITS - 1 - k)
      ) u_level (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .valid_in(valid_s[k]),
         .is_hilbert_in(is_hilbert_s[k]),
         .x_in(x_s[k]),
         .y_in(y_s[k]),
         .dist_in(dist_s[k]),
         .z_high_in(z_high_s[k]),
         .alt_index_in(alt_index_s[k]),
         .valid_out(valid_s[k+1]),
         .is_hilbert_out(is_hilbert_s[k+1]),
         .x_out(x_s[k+1]),
         .y_out(y_s[k+1]),
         .dist_out(dist_s[k+1]),
         .z_high_out(z_high_s[k+1]),
         .alt_index_out(alt_index_s[k+1])
      );
   end

   // hilbert distance stays below 4^b, so z above it merges by or
   always_comb begin
      if (is_hilbert_s[MAX_AXIS_BITS]) begin
         rsp_index_in = INDEX_W'(CALC_W'(dist_s[MAX_AXIS_BITS]) | z_high_s[MAX_AXIS_BITS]);
      end else begin
         rsp_index_in = INDEX_W'(alt_index_s[MAX_AXIS_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_s[MAX_AXIS_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_curve_index = rsp_index_ff;

   // x and y are fully consumed by the last level
   logic unused_xy;
   assign unused_xy = ^{x_s[MAX_AXIS_BITS], y_s[MAX_AXIS_BITS]};

endmodule

[dv/curve_index_checker.sv]
`timescale 1ns / 1ps
module curve_index_checker #(
   parameter int MAX_AXIS_BITS = gcci_pkg::MAX_AXIS_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [gcci_pkg::COORD_W-1:0] req_cell_x,
   input  logic [gcci_pkg::COORD_W-1:0] req_cell_y,
   input  logic [gcci_pkg::COORD_W-1:0] req_cell_z,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [gcci_pkg::INDEX_W-1:0] rsp_curve_index,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [gcci_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gcci_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int pending_count
);
   import gcci_pkg::*;

   gcci_cfg_type grid_cfg;
   logic [INDEX_W-1:0] cell_positions[$];
   logic [INDEX_W-1:0] want;
   int fails = 0;

   // scatter the low nbits of v so that bit i lands on bit i*stride
   function automatic logic [31:0] spread_coord(input logic [31:0] v, input int nbits,
                                                input int stride);
      logic [31:0] r;
      int i;
      r = '0;
      for (i = 0; i < nbits; i++) begin
         r[i*stride] = v[i];
      end
      return r;
   endfunction

   function automatic logic [31:0] hilbert_distance(input int nbits, input logic [31:0] hx,
                                                    input logic [31:0] hy);
      logic [31:0] walked, span, low, tmp;
      logic [1:0] quad;
      logic qx, qy;
      int lvl;
      walked = '0;
      for (lvl = nbits - 1; lvl >= 0; lvl--) begin
         span = 32'd1 << lvl;
         low = span - 32'd1;
         qx = |(hx & span);
         qy = |(hy & span);
         // quadrant order 0,1,2,3 is (0,0) (0,1) (1,1) (1,0)
         quad = {qx, qx ^ qy};
         walked = walked + span * span * {30'd0, quad};
         if (!qy) begin
            if (qx) begin
               hx = hx ^ low;
               hy = hy ^ low;
            end
            tmp = hx;
            hx = hy;
            hy = tmp;
         end
         hx = hx & low;
         hy = hy & low;
      end
      return walked;
   endfunction

   function automatic logic [INDEX_W-1:0] cell_position(input gcci_cfg_type cfg,
                                                        input logic [COORD_W-1:0] cx,
                                                        input logic [COORD_W-1:0] cy,
                                                        input logic [COORD_W-1:0] cz);
      int b;
      logic [31:0] mask, px, py, pz, pos;
      b = (cfg.axis_bits > MAX_AXIS_BITS) ? MAX_AXIS_BITS : int'(cfg.axis_bits);
      mask = (32'd1 << b) - 32'd1;
      px = {22'd0, cx} & mask;
      py = {22'd0, cy} & mask;
      pz = cfg.three_dim ? ({22'd0, cz} & mask) : 32'd0;
      case (cfg.curve_mode)
         MODE_ZORDER: begin
            if (cfg.three_dim) begin
               pos = spread_coord(px, b, 3) | (spread_coord(py, b, 3) << 1)
                     | (spread_coord(pz, b, 3) << 2);
            end else begin
               pos = spread_coord(px, b, 2) | (spread_coord(py, b, 2) << 1);
            end
         end
         MODE_HILBERT: begin
            pos = hilbert_distance(b, px, py) + (pz << (2 * b));
         end
         // the spare mode code falls back to row-major
         default: begin
            pos = px + (py << b) + (pz << (2 * b));
         end
      endcase
      return pos[INDEX_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         grid_cfg.curve_mode = CURVE_MODE_RESET;
         grid_cfg.three_dim = THREE_DIM_RESET;
         grid_cfg.axis_bits = AXIS_BITS_RESET;
         cell_positions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CURVE_MODE: grid_cfg.curve_mode = csr_wdata[1:0];
               CSR_THREE_DIM: grid_cfg.three_dim = csr_wdata[0];
               CSR_AXIS_BITS: grid_cfg.axis_bits = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (cell_positions.size() == 0) begin
               fails++;
               $error("curve_index expected none actual %0d", rsp_curve_index);
            end else begin
               want = cell_positions.pop_front();
               if (rsp_curve_index !== want) begin
                  fails++;
                  $error("curve_index expected %0d actual %0d", want, rsp_curve_index);
               end
            end
         end
         if (req_valid && !req_stall) begin
            cell_positions.push_back(cell_position(grid_cfg, req_cell_x, req_cell_y,
                                                   req_cell_z));
         end
      end
      fail_count <= fails;
      pending_count <= cell_positions.size();
   end

endmodule

[dv/tb_grid_cell_curve_index.sv]
`timescale 1ns / 1ps
module tb_grid_cell_curve_index;
   import gcci_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_type;

   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   // mode code with no ordering of its own
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int PIPE_DEPTH = MAX_AXIS_BITS_DEF + 2;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 116;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_W-1:0] req_cell_x = '0;
   logic [COORD_W-1:0] req_cell_y = '0;
   logic [COORD_W-1:0] req_cell_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [INDEX_W-1:0] rsp_curve_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count;
   int pending_count;
   idle_mode_type idle_style = IDLE_NONE;

   always #5 clock = ~clock;

   grid_cell_curve_index DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y),
      .req_cell_z(req_cell_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_curve_index(rsp_curve_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   curve_index_checker index_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y),
      .req_cell_z(req_cell_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_curve_index(rsp_curve_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   function automatic int idle_cycles();
      case (idle_style)
         IDLE_NONE: return 0;
         IDLE_HEAVY: return $urandom_range(0, 18);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord(input logic [AXIS_REG_W-1:0] abits);
      int unsigned edge_val;
      int pick;
      edge_val = (abits >= MAX_AXIS_BITS_DEF) ? 1023 : (1 << abits) - 1;
      pick = $urandom_range(0, 19);
      if (pick < 13) return COORD_W'($urandom_range(0, 1023));
      else if (pick < 17) return COORD_W'($urandom_range(0, edge_val));
      else if (pick == 17) return COORD_W'(edge_val);
      else if (pick == 18) return '0;
      else return '1;
   endfunction

   task automatic send_cell(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] cz);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_x <= cx;
      req_cell_y <= cy;
      req_cell_z <= cz;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      // wait for a clock edge first so the last accepted transaction shows in pending_count
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need one assignment per edge
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_grid(input logic [1:0] mode, input logic dim3,
                             input logic [AXIS_REG_W-1:0] abits);
      wait_drained();
      write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      // upper data bits are don't-care for the narrow registers
      write_reg(CSR_CURVE_MODE, {2'($urandom), mode});
      write_reg(CSR_THREE_DIM, {3'($urandom), dim3});
      write_reg(CSR_AXIS_BITS, abits);
      csr_valid <= 1'b0;
   endtask

   initial begin : response_side
      int hold;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         // two long hold-offs let the pipeline fill and push back on the sender
         if (taken == 300 || taken == 900) hold = 300;
         else hold = idle_cycles();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      int phase;
      int item;
      int pick;
      logic [1:0] mode;
      logic dim3;
      logic [AXIS_REG_W-1:0] abits;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings out of reset: z-order, 2d, 16 cells per axis
      idle_style = IDLE_NONE;
      send_cell(10'h000, 10'h000, 10'h000);
      send_cell(10'h3FF, 10'h3FF, 10'h3FF);
      send_cell(10'h00F, 10'h3F0, 10'h155);

      apply_grid(MODE_ROW_MAJOR, 1'b1, 4'd10);
      send_cell(10'h3FF, 10'h3FF, 10'h3FF);
      send_cell(10'h000, 10'h000, 10'h000);
      send_cell(10'h001, 10'h002, 10'h003);

      // smallest grid visits three of the four hilbert quadrants: (0,0), (0,1) and (1,1)
      apply_grid(MODE_HILBERT, 1'b0, 4'd1);
      send_cell(10'h000, 10'h000, 10'h3FF);
      send_cell(10'h000, 10'h001, 10'h000);
      send_cell(10'h001, 10'h001, 10'h000);
      send_cell(10'h3FE, 10'h3FE, 10'h000);

      // spare mode code and axis_bits past the limit
      apply_grid(MODE_SPARE, 1'b1, 4'd15);
      send_cell(10'h3FF, 10'h000, 10'h200);
      send_cell(10'h005, 10'h3FF, 10'h000);

      apply_grid(MODE_ZORDER, 1'b1, 4'd10);
      send_cell(10'h3FF, 10'h3FF, 10'h3FF);
      send_cell(10'h2AA, 10'h155, 10'h3FF);

      // single-cell grid
      apply_grid(MODE_HILBERT, 1'b1, 4'd0);
      send_cell(10'h3FF, 10'h3FF, 10'h3FF);

      apply_grid(MODE_HILBERT, 1'b0, 4'd10);
      send_cell(10'h3FF, 10'h000, 10'h000);
      send_cell(10'h000, 10'h3FF, 10'h005);
      send_cell(10'h3FF, 10'h3FF, 10'h000);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = 2'($urandom_range(0, 3));
         dim3 = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 9);
         if (pick < 7) abits = AXIS_REG_W'($urandom_range(1, 10));
         else if (pick == 7) abits = '0;
         else if (pick == 8) abits = AXIS_REG_W'($urandom_range(11, 15));
         else abits = 4'd10;
         apply_grid(mode, dim3, abits);
         idle_style = idle_mode_type'(phase % 3);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            send_cell(rand_coord(abits), rand_coord(abits), rand_coord(abits));
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/gcci_pkg.sv
hdl/gcci_prep.sv
hdl/gcci_hilb_level.sv
hdl/grid_cell_curve_index.sv
dv/curve_index_checker.sv
dv/tb_grid_cell_curve_index.sv
